@@ hw/rtl/cfdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc_pkg
// Shared types and constants of the cppm frame decoder with calibration.
// ----------------------------------------------------------------------------
package cfdc_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int STORE_DEPTH  = 8;
    localparam int STORE_IDX_W  = 3;
    localparam int SLOT_VAL_W   = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // pulses shorter than this many timer ticks are dropped
    localparam logic [15:0] MIN_TICKS = 16'd20;

    // us = ticks * 100 / 166 = ticks * 50 / 83, exact over 16-bit ticks
    localparam int          US_SHIFT = 28;
    localparam logic [27:0] US_RECIP = 28'd161708150;
    localparam int          PROD_W   = 16 + US_SHIFT;

    localparam logic [13:0]        LOW_INIT      = 14'd10000;
    localparam logic signed [13:0] CENTRE_WINDOW = 14'sd20;
    localparam logic [SLOT_VAL_W-1:0] SLOT_SAT   = 12'd4095;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STR_CH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULS_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULS_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd7;

    // configuration reset values
    localparam logic [2:0]  RST_THR_CH   = 3'd2;
    localparam logic [2:0]  RST_STR_CH   = 3'd0;
    localparam logic [15:0] RST_SYNC_MIN = 16'd3000;
    localparam logic [15:0] RST_SYNC_MAX = 16'd30000;
    localparam logic [15:0] RST_PULS_MIN = 16'd600;
    localparam logic [15:0] RST_PULS_MAX = 16'd2500;
    localparam logic [11:0] RST_SPAN     = 12'd600;
    localparam logic [7:0]  RST_TIMEOUT  = 8'd50;

    typedef enum logic [1:0] {
        MODE_NOSIG = 2'd0,
        MODE_CALIB = 2'd1,
        MODE_READY = 2'd2
    } t_mode;

    // converted beat handed from the input stage to the decoder
    typedef struct packed {
        logic        action;
        logic        short_pulse;
        logic [15:0] us;
    } t_item;

endpackage
`default_nettype wire

@@ hw/rtl/cfdc_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc_conv
// Input stage: registers a beat with its width converted to microseconds.
// ----------------------------------------------------------------------------
module cfdc_conv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic                i_take,
    input  wire logic                i_action,
    input  wire logic [15:0]         i_pulse_ticks,
    output cfdc_pkg::t_item          o_item,
    output logic                     o_valid
);

    logic [cfdc_pkg::PROD_W-1:0] prod;
    logic                        r_valid;
    logic                        n_valid;
    cfdc_pkg::t_item             r_item;

    // multiply by the scaled reciprocal of 83/50
    assign prod = cfdc_pkg::PROD_W'(i_pulse_ticks) * cfdc_pkg::PROD_W'(cfdc_pkg::US_RECIP);

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.action      <= i_action;
            r_item.short_pulse <= (i_pulse_ticks < cfdc_pkg::MIN_TICKS);
            r_item.us          <= prod[cfdc_pkg::PROD_W-1:cfdc_pkg::US_SHIFT];
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

@@ hw/rtl/cfdc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc_core
// Frame assembly, mode machine, configuration and result register.
// ----------------------------------------------------------------------------
module cfdc_core #(
    parameter int CHANNELS = cfdc_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_take,
    input  wire logic                              i_out_stall,
    input  wire cfdc_pkg::t_item                   i_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [cfdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cfdc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_out_valid,
    output logic [1:0]                             o_run_mode,
    output logic                                   o_frame_done,
    output logic                                   o_drive_valid,
    output logic signed [12:0]                     o_throttle_offset,
    output logic signed [12:0]                     o_steering_offset,
    output logic                                   o_signal_lost,
    output logic [15:0]                            o_frame_total,
    output logic [15:0]                            o_pulse_us
);

    localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VW     = cfdc_pkg::SLOT_VAL_W;

    // configuration
    logic [2:0]  r_thr_ch, r_str_ch;
    logic [15:0] r_sync_min, r_sync_max, r_puls_min, r_puls_max;
    logic [11:0] r_span;
    logic [7:0]  r_timeout;

    // decoder state
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_armed, n_armed;
    logic [VW-1:0]       r_store [cfdc_pkg::STORE_DEPTH];
    logic                r_have, n_have;
    cfdc_pkg::t_mode     r_mode, n_mode;
    logic [13:0]         r_tlow, n_tlow;
    logic [VW-1:0]       r_thigh, n_thigh;
    logic [VW-1:0]       r_tmid, n_tmid;
    logic [VW-1:0]       r_smid, n_smid;
    logic [15:0]         r_fcount, n_fcount;
    logic [7:0]          r_idle, n_idle;
    logic [15:0]         r_last, n_last;

    // result register
    logic                r_out_valid, n_out_valid;
    cfdc_pkg::t_mode     r_o_mode;
    logic                r_o_done, n_done;
    logic                r_o_drive, n_drive;
    logic signed [12:0]  r_o_thr, n_thr_off;
    logic signed [12:0]  r_o_str, n_str_off;
    logic                r_o_lost, n_lost;
    logic [15:0]         r_o_fcount, r_o_last;

    logic [SLOT_W:0]                  slot_nx;
    logic [31:0]                      slot_wide;
    logic [cfdc_pkg::STORE_IDX_W-1:0] wr_idx;
    logic                             wr_en;
    logic                             clr;
    logic [VW-1:0]                    sat_us;
    logic [VW-1:0]                    thr, str;
    logic                             is_sync, is_chan;

    assign slot_nx   = {1'b0, r_slot} + 1'b1;
    assign slot_wide = 32'(r_slot);
    assign wr_idx    = slot_wide[cfdc_pkg::STORE_IDX_W-1:0];
    assign sat_us    = (i_item.us > 16'(cfdc_pkg::SLOT_SAT)) ? cfdc_pkg::SLOT_SAT
                                                            : i_item.us[VW-1:0];
    assign is_sync   = (i_item.us >= r_sync_min) && (i_item.us < r_sync_max);
    assign is_chan   = (i_item.us >= r_puls_min) && (i_item.us < r_puls_max);

    // channel beat on an armed frame lands in its slot while the slot exists
    assign wr_en     = i_take && !i_item.action && !i_item.short_pulse && !is_sync &&
                       is_chan && r_armed && (32'(r_slot) < cfdc_pkg::STORE_DEPTH);

    // the slot written by this beat is visible to the frame it completes
    assign thr = (wr_en && (wr_idx == r_thr_ch)) ? sat_us : r_store[r_thr_ch];
    assign str = (wr_en && (wr_idx == r_str_ch)) ? sat_us : r_store[r_str_ch];

    always_comb begin
        logic [13:0]        c_low;
        logic [VW-1:0]      c_high;
        logic [14:0]        c_sum;
        logic [VW-1:0]      c_mid;
        logic signed [13:0] c_diff;
        logic [13:0]        c_range;
        cfdc_pkg::t_mode    f_mode;

        n_slot    = r_slot;
        n_armed   = r_armed;
        n_have    = r_have;
        n_mode    = r_mode;
        n_tlow    = r_tlow;
        n_thigh   = r_thigh;
        n_tmid    = r_tmid;
        n_smid    = r_smid;
        n_fcount  = r_fcount;
        n_idle    = r_idle;
        n_last    = r_last;
        n_done    = 1'b0;
        n_drive   = 1'b0;
        n_lost    = 1'b0;
        n_thr_off = '0;
        n_str_off = '0;
        clr       = 1'b0;
        c_low     = '0;
        c_high    = '0;
        c_sum     = '0;
        c_mid     = '0;
        c_diff    = '0;
        c_range   = '0;
        f_mode    = r_mode;

        if (i_take) begin
            if (i_item.action) begin
                if (r_have) begin
                    if (r_idle >= r_timeout) begin
                        n_lost = 1'b1;
                        n_have = 1'b0;
                        n_mode = cfdc_pkg::MODE_NOSIG;
                        n_idle = '0;
                    end else begin
                        n_idle = r_idle + 8'd1;
                    end
                end
            end else if (!i_item.short_pulse) begin
                n_last = i_item.us;
                if (is_sync) begin
                    n_slot  = '0;
                    n_armed = 1'b1;
                    clr     = 1'b1;
                end else if (is_chan && r_armed) begin
                    if (32'(slot_nx) >= CHANNELS) begin
                        n_slot   = '0;
                        n_armed  = 1'b0;
                        n_fcount = r_fcount + 16'd1;
                        n_done   = 1'b1;
                        n_idle   = '0;
                        f_mode   = r_mode;
                        c_low    = r_tlow;
                        c_high   = r_thigh;
                        if (!r_have) begin
                            n_have = 1'b1;
                            f_mode = cfdc_pkg::MODE_CALIB;
                            c_low  = cfdc_pkg::LOW_INIT;
                            c_high = '0;
                            n_smid = str;
                        end
                        n_tlow  = c_low;
                        n_thigh = c_high;
                        n_mode  = f_mode;
                        case (f_mode)
                            cfdc_pkg::MODE_READY: begin
                                n_drive   = 1'b1;
                                n_thr_off = $signed({1'b0, thr}) - $signed({1'b0, r_tmid});
                                n_str_off = $signed({1'b0, str}) - $signed({1'b0, r_smid});
                            end
                            cfdc_pkg::MODE_CALIB: begin
                                if ({2'b00, thr} < c_low) begin
                                    c_low = {2'b00, thr};
                                end
                                if (thr > c_high) begin
                                    c_high = thr;
                                end
                                c_sum   = {1'b0, c_low} + {3'b000, c_high};
                                c_mid   = c_sum[VW:1];
                                c_diff  = $signed({2'b00, thr}) - $signed({2'b00, c_mid});
                                c_range = ({2'b00, c_high} >= c_low) ?
                                          ({2'b00, c_high} - c_low) : 14'd0;
                                n_tlow  = c_low;
                                n_thigh = c_high;
                                n_tmid  = c_mid;
                                if ((c_range > {2'b00, r_span}) &&
                                    (c_diff > -cfdc_pkg::CENTRE_WINDOW) &&
                                    (c_diff < cfdc_pkg::CENTRE_WINDOW)) begin
                                    n_mode = cfdc_pkg::MODE_READY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        n_slot = slot_nx[SLOT_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_ch    <= cfdc_pkg::RST_THR_CH;
            r_str_ch    <= cfdc_pkg::RST_STR_CH;
            r_sync_min  <= cfdc_pkg::RST_SYNC_MIN;
            r_sync_max  <= cfdc_pkg::RST_SYNC_MAX;
            r_puls_min  <= cfdc_pkg::RST_PULS_MIN;
            r_puls_max  <= cfdc_pkg::RST_PULS_MAX;
            r_span      <= cfdc_pkg::RST_SPAN;
            r_timeout   <= cfdc_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cfdc_pkg::CFG_THR_CH:   r_thr_ch   <= i_cfg_data[2:0];
                cfdc_pkg::CFG_STR_CH:   r_str_ch   <= i_cfg_data[2:0];
                cfdc_pkg::CFG_SYNC_MIN: r_sync_min <= i_cfg_data;
                cfdc_pkg::CFG_SYNC_MAX: r_sync_max <= i_cfg_data;
                cfdc_pkg::CFG_PULS_MIN: r_puls_min <= i_cfg_data;
                cfdc_pkg::CFG_PULS_MAX: r_puls_max <= i_cfg_data;
                cfdc_pkg::CFG_SPAN:     r_span     <= i_cfg_data[11:0];
                cfdc_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_armed     <= 1'b0;
            r_have      <= 1'b0;
            r_mode      <= cfdc_pkg::MODE_NOSIG;
            r_tlow      <= '0;
            r_thigh     <= '0;
            r_tmid      <= '0;
            r_smid      <= '0;
            r_fcount    <= '0;
            r_idle      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot      <= n_slot;
            r_armed     <= n_armed;
            r_have      <= n_have;
            r_mode      <= n_mode;
            r_tlow      <= n_tlow;
            r_thigh     <= n_thigh;
            r_tmid      <= n_tmid;
            r_smid      <= n_smid;
            r_fcount    <= n_fcount;
            r_idle      <= n_idle;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // sync clears the slots so a selector outside the frame reads zero
    always_ff @(posedge i_clk) begin
        if (clr) begin
            for (int k = 0; k < cfdc_pkg::STORE_DEPTH; k++) begin
                r_store[k] <= '0;
            end
        end else if (wr_en) begin
            r_store[wr_idx] <= sat_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_o_mode   <= n_mode;
            r_o_done   <= n_done;
            r_o_drive  <= n_drive;
            r_o_thr    <= n_thr_off;
            r_o_str    <= n_str_off;
            r_o_lost   <= n_lost;
            r_o_fcount <= n_fcount;
            r_o_last   <= n_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_run_mode        = r_o_mode;
    assign o_frame_done      = r_o_done;
    assign o_drive_valid     = r_o_drive;
    assign o_throttle_offset = r_o_thr;
    assign o_steering_offset = r_o_str;
    assign o_signal_lost     = r_o_lost;
    assign o_frame_total     = r_o_fcount;
    assign o_pulse_us        = r_o_last;

endmodule
`default_nettype wire

@@ hw/rtl/cppm_frame_decoder_with_calibration.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cppm_frame_decoder_with_calibration
// Decodes a cppm pulse train into frames and calibrated drive offsets.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one beat is either a captured pulse
// width in timer ticks (i_action low) or a centisecond tick (i_action high).
// Output channel (o_out_valid / i_out_stall): exactly one result beat per
// input beat, in order, with mode, frame flags, offsets and counters.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index; write
// only while no beat is in flight.
// A beat passes an input stage holding the tick-to-microsecond product, then
// a decode stage into the result register. One beat is taken every cycle
// while the output does not stall; decode state is updated as each beat is
// taken, so beats may follow back to back.
// A stalled receiver holds the result register; the input stage still takes
// one more beat, after which o_in_stall follows i_out_stall.
// Reset (synchronous, active low) empties both stages, restores register
// defaults and returns the decoder to no-signal, waiting for a sync pulse.
// ----------------------------------------------------------------------------
module cppm_frame_decoder_with_calibration #(
    parameter int CHANNELS = cfdc_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_action,
    input  wire logic [15:0]                       i_pulse_ticks,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_run_mode,
    output logic                                   o_frame_done,
    output logic                                   o_drive_valid,
    output logic signed [12:0]                     o_throttle_offset,
    output logic signed [12:0]                     o_steering_offset,
    output logic                                   o_signal_lost,
    output logic [15:0]                            o_frame_total,
    output logic [15:0]                            o_pulse_us,
    input  wire logic                              i_cfg_we,
    input  wire logic [cfdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cfdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cfdc_pkg::t_item item;
    logic            item_valid;
    logic            dec_ready;
    logic            in_ready;
    logic            load;
    logic            take;

    assign dec_ready  = !o_out_valid || !i_out_stall;
    assign in_ready   = !item_valid || dec_ready;
    assign o_in_stall = !in_ready;
    assign load       = i_in_valid && in_ready;
    assign take       = item_valid && dec_ready;

    cfdc_conv u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_take        (take),
        .i_action      (i_action),
        .i_pulse_ticks (i_pulse_ticks),
        .o_item        (item),
        .o_valid       (item_valid)
    );

    cfdc_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (take),
        .i_out_stall       (i_out_stall),
        .i_item            (item),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .o_run_mode        (o_run_mode),
        .o_frame_done      (o_frame_done),
        .o_drive_valid     (o_drive_valid),
        .o_throttle_offset (o_throttle_offset),
        .o_steering_offset (o_steering_offset),
        .o_signal_lost     (o_signal_lost),
        .o_frame_total     (o_frame_total),
        .o_pulse_us        (o_pulse_us)
    );

`ifndef SYNTHESIS
    // offsets only come from a completed frame in ready mode
    a_drive_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_valid) |->
            (o_frame_done && (o_run_mode == cfdc_pkg::MODE_READY)))
        else $error("drive offsets outside a ready frame");

    a_offsets_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_valid) |->
            ((o_throttle_offset == 13'sd0) && (o_steering_offset == 13'sd0)))
        else $error("non-zero offsets without drive");

    a_lost_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_signal_lost) |->
            ((o_run_mode == cfdc_pkg::MODE_NOSIG) && !o_frame_done))
        else $error("signal loss with a live mode or frame");

    a_frame_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_run_mode != cfdc_pkg::MODE_NOSIG))
        else $error("completed frame left no-signal mode");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_valid && o_out_valid && i_out_stall) |=> item_valid)
        else $error("input stage dropped a beat under stall");
`endif

endmodule
`default_nettype wire

@@ verif/cfdc_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdc_result_check
// Watches both channels and the register port of the cppm frame decoder,
// works out the result of every accepted input beat from its own copy of the
// decode and calibration state, and compares each result beat in order.
// ----------------------------------------------------------------------------
module cfdc_result_check
    import cfdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_action,
    input  wire logic [15:0]           i_pulse_ticks,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [1:0]            i_run_mode,
    input  wire logic                  i_frame_done,
    input  wire logic                  i_drive_valid,
    input  wire logic signed [12:0]    i_throttle_offset,
    input  wire logic signed [12:0]    i_steering_offset,
    input  wire logic                  i_signal_lost,
    input  wire logic [15:0]           i_frame_total,
    input  wire logic [15:0]           i_pulse_us,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    typedef struct packed {
        logic [1:0]         mode;
        logic               done;
        logic               drive;
        logic signed [12:0] thr_off;
        logic signed [12:0] str_off;
        logic               lost;
        logic [15:0]        frames;
        logic [15:0]        width;
    } beat_result_t;

    // register copies
    logic [2:0]  cfg_thr_ch;
    logic [2:0]  cfg_str_ch;
    logic [15:0] cfg_sync_min;
    logic [15:0] cfg_sync_max;
    logic [15:0] cfg_puls_min;
    logic [15:0] cfg_puls_max;
    logic [11:0] cfg_span;
    logic [7:0]  cfg_timeout;

    // decoder state
    int                    slot_idx;
    logic                  armed;
    logic [SLOT_VAL_W-1:0] slots [STORE_DEPTH];
    logic                  have_sig;
    t_mode                 dec_mode;
    logic [13:0]           thr_low;
    logic [11:0]           thr_high;
    logic [11:0]           thr_mid;
    logic [11:0]           str_mid;
    logic [15:0]           frame_cnt;
    logic [7:0]            idle_cnt;
    logic [15:0]           width_us;

    beat_result_t pending_results[$];
    int           err_cnt = 0;

    assign o_errors = err_cnt;
    initial o_pending = 0;

    function automatic beat_result_t decode_beat(input logic act, input logic [15:0] ticks);
        beat_result_t r;
        int           us;
        int           thr;
        int           str;
        int           diff;
        int           span;
        r = '0;
        if (act) begin
            if (have_sig) begin
                if (idle_cnt >= cfg_timeout) begin
                    r.lost   = 1'b1;
                    have_sig = 1'b0;
                    dec_mode = MODE_NOSIG;
                    idle_cnt = '0;
                end else begin
                    idle_cnt = idle_cnt + 8'd1;
                end
            end
        end else if (ticks >= MIN_TICKS) begin
            us       = int'(ticks) * 100 / 166;
            width_us = us[15:0];
            if (us >= int'(cfg_sync_min) && us < int'(cfg_sync_max)) begin
                slot_idx = 0;
                armed    = 1'b1;
                for (int i = 0; i < STORE_DEPTH; i++) slots[i] = '0;
            end else if (us >= int'(cfg_puls_min) && us < int'(cfg_puls_max) && armed) begin
                if (slot_idx < STORE_DEPTH) begin
                    slots[slot_idx] = (us > int'(SLOT_SAT)) ? SLOT_SAT : us[11:0];
                end
                slot_idx++;
                if (slot_idx >= CHANNELS_DEF) begin
                    frame_cnt = frame_cnt + 16'd1;
                    slot_idx  = 0;
                    armed     = 1'b0;
                    r.done    = 1'b1;
                    thr       = int'(slots[cfg_thr_ch]);
                    str       = int'(slots[cfg_str_ch]);
                    // first frame after reset or loss restarts calibration
                    if (!have_sig) begin
                        have_sig = 1'b1;
                        dec_mode = MODE_CALIB;
                        thr_high = '0;
                        thr_low  = LOW_INIT;
                        str_mid  = str[11:0];
                    end
                    idle_cnt = '0;
                    if (dec_mode == MODE_READY) begin
                        r.drive   = 1'b1;
                        diff      = thr - int'(thr_mid);
                        r.thr_off = diff[12:0];
                        diff      = str - int'(str_mid);
                        r.str_off = diff[12:0];
                    end
                    if (dec_mode == MODE_CALIB) begin
                        if (thr < int'(thr_low)) thr_low = thr[13:0];
                        if (thr > int'(thr_high)) thr_high = thr[11:0];
                        span    = (int'(thr_low) + int'(thr_high)) / 2;
                        thr_mid = span[11:0];
                        diff    = thr - int'(thr_mid);
                        span    = (int'(thr_high) >= int'(thr_low)) ?
                                  int'(thr_high) - int'(thr_low) : 0;
                        if (span > int'(cfg_span) && diff > -20 && diff < 20) begin
                            dec_mode = MODE_READY;
                        end
                    end
                end
            end
        end
        r.mode   = dec_mode;
        r.frames = frame_cnt;
        r.width  = width_us;
        return r;
    endfunction

    task automatic check_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        beat_result_t want;
        if (!i_rst_n) begin
            cfg_thr_ch   = RST_THR_CH;
            cfg_str_ch   = RST_STR_CH;
            cfg_sync_min = RST_SYNC_MIN;
            cfg_sync_max = RST_SYNC_MAX;
            cfg_puls_min = RST_PULS_MIN;
            cfg_puls_max = RST_PULS_MAX;
            cfg_span     = RST_SPAN;
            cfg_timeout  = RST_TIMEOUT;
            slot_idx     = 0;
            armed        = 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) slots[i] = '0;
            have_sig     = 1'b0;
            dec_mode     = MODE_NOSIG;
            thr_low      = '0;
            thr_high     = '0;
            thr_mid      = '0;
            str_mid      = '0;
            frame_cnt    = '0;
            idle_cnt     = '0;
            width_us     = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THR_CH:   cfg_thr_ch   = i_cfg_data[2:0];
                    CFG_STR_CH:   cfg_str_ch   = i_cfg_data[2:0];
                    CFG_SYNC_MIN: cfg_sync_min = i_cfg_data;
                    CFG_SYNC_MAX: cfg_sync_max = i_cfg_data;
                    CFG_PULS_MIN: cfg_puls_min = i_cfg_data;
                    CFG_PULS_MAX: cfg_puls_max = i_cfg_data;
                    CFG_SPAN:     cfg_span     = i_cfg_data[11:0];
                    CFG_TIMEOUT:  cfg_timeout  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(decode_beat(i_action, i_pulse_ticks));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result beat with nothing expected, expected none, actual mode %0d",
                             $time, i_run_mode);
                end else begin
                    want = pending_results.pop_front();
                    check_field("run_mode", want.mode, i_run_mode);
                    check_field("frame_done", want.done, i_frame_done);
                    check_field("drive_valid", want.drive, i_drive_valid);
                    check_field("throttle_offset", want.thr_off, i_throttle_offset);
                    check_field("steering_offset", want.str_off, i_steering_offset);
                    check_field("signal_lost", want.lost, i_signal_lost);
                    check_field("frame_total", want.frames, i_frame_total);
                    check_field("pulse_us", want.width, i_pulse_us);
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the cppm frame decoder with pulse trains, timer ticks and register
// settings: a short directed opening, then mostly well-formed frames with
// random content mixed with noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import cfdc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 64;
    localparam int US_CAP      = 39478;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  i_action      = 1'b0;
    logic [15:0]           i_pulse_ticks = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_run_mode;
    logic               o_frame_done;
    logic               o_drive_valid;
    logic signed [12:0] o_throttle_offset;
    logic signed [12:0] o_steering_offset;
    logic               o_signal_lost;
    logic [15:0]        o_frame_total;
    logic [15:0]        o_pulse_us;

    int chk_errors;
    int chk_pending;
    int cycles      = 0;
    int beats_sent  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    // current register values, mirrored for shaping the stimulus
    int set_thr_ch   = RST_THR_CH;
    int set_sync_min = RST_SYNC_MIN;
    int set_sync_max = RST_SYNC_MAX;
    int set_puls_min = RST_PULS_MIN;
    int set_puls_max = RST_PULS_MAX;
    int set_timeout  = RST_TIMEOUT;

    cppm_frame_decoder_with_calibration dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_pulse_ticks    (i_pulse_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_run_mode       (o_run_mode),
        .o_frame_done     (o_frame_done),
        .o_drive_valid    (o_drive_valid),
        .o_throttle_offset(o_throttle_offset),
        .o_steering_offset(o_steering_offset),
        .o_signal_lost    (o_signal_lost),
        .o_frame_total    (o_frame_total),
        .o_pulse_us       (o_pulse_us),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    cfdc_result_check chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_pulse_ticks    (i_pulse_ticks),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_run_mode       (o_run_mode),
        .i_frame_done     (o_frame_done),
        .i_drive_valid    (o_drive_valid),
        .i_throttle_offset(o_throttle_offset),
        .i_steering_offset(o_steering_offset),
        .i_signal_lost    (o_signal_lost),
        .i_frame_total    (o_frame_total),
        .i_pulse_us       (o_pulse_us),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (chk_errors),
        .o_pending        (chk_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[cppm_frame_decoder_with_calibration] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts plus an occasional long hold-off
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    // smallest tick count that converts back to exactly this many microseconds
    function automatic logic [15:0] ticks_for(input int us);
        int t;
        t = ((us > US_CAP ? US_CAP : us) * 166 + 99) / 100;
        return t[15:0];
    endfunction

    task automatic send_beat(input logic act, input logic [15:0] ticks);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_pulse_ticks <= ticks;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_pulse_us(input int us);
        send_beat(1'b0, ticks_for(us));
    endtask

    task automatic send_tick();
        send_beat(1'b1, 16'($urandom_range(0, 65535)));
    endtask

    // channel values that are taken as channel beats, clear of the sync range
    task automatic chan_window(output int lo, output int hi);
        lo = (set_puls_min < 13) ? 13 : set_puls_min;
        hi = set_puls_max - 1;
        if (set_sync_min <= hi && set_sync_max > lo) begin
            if (set_sync_min > lo) hi = set_sync_min - 1;
            else lo = set_sync_max;
        end
        if (hi > US_CAP) hi = US_CAP;
        if (lo > hi) lo = hi;
    endtask

    task automatic send_frame(input int n_slots);
        int lo;
        int hi;
        int ctr;
        int v;
        int sync_hi;
        chan_window(lo, hi);
        ctr     = (((lo > 4095) ? 4095 : lo) + ((hi > 4095) ? 4095 : hi)) / 2;
        sync_hi = (set_sync_max - 1 > US_CAP) ? US_CAP : set_sync_max - 1;
        send_pulse_us($urandom_range(set_sync_min, sync_hi));
        for (int s = 0; s < n_slots; s++) begin
            if (s == set_thr_ch) begin
                // stick swept to both ends and back to centre
                case ($urandom_range(0, 3))
                    0:       v = lo + $urandom_range(0, 20);
                    1:       v = hi - $urandom_range(0, 20);
                    2:       v = ctr + $urandom_range(0, 20) - 10;
                    default: v = $urandom_range(lo, hi);
                endcase
            end else begin
                v = $urandom_range(lo, hi);
            end
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            send_pulse_us(v);
            if ($urandom_range(0, 9) == 0) send_tick();
        end
    endtask

    task automatic send_noise();
        int lo;
        int hi;
        chan_window(lo, hi);
        case ($urandom_range(0, 3))
            0:       send_beat(1'b0, 16'($urandom_range(0, 19)));
            1:       send_beat(1'b0, 16'($urandom_range(0, 65535)));
            2:       send_frame($urandom_range(0, CHANNELS_DEF - 1));
            default: send_pulse_us($urandom_range(lo, hi));
        endcase
    endtask

    task automatic run_phase(input int budget);
        int first;
        int n;
        first = beats_sent;
        while (beats_sent - first < budget) begin
            if (!quiet && $urandom_range(0, 24) == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            case ($urandom_range(0, 9))
                7: begin
                    if ($urandom_range(0, 3) == 0 && set_timeout < 64)
                        n = set_timeout + $urandom_range(1, 3);
                    else
                        n = $urandom_range(1, 3);
                    repeat (n) send_tick();
                end
                8, 9:    send_noise();
                default: send_frame(CHANNELS_DEF);
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic use_setting(input int thr, input int str, input int smin, input int smax,
                               input int pmin, input int pmax, input int span, input int tmo);
        set_thr_ch   = thr;
        set_sync_min = smin;
        set_sync_max = smax;
        set_puls_min = pmin;
        set_puls_max = pmax;
        set_timeout  = tmo;
        write_reg(CFG_THR_CH, thr);
        write_reg(CFG_STR_CH, str);
        write_reg(CFG_SYNC_MIN, smin);
        write_reg(CFG_SYNC_MAX, smax);
        write_reg(CFG_PULS_MIN, pmin);
        write_reg(CFG_PULS_MAX, pmax);
        write_reg(CFG_SPAN, span);
        write_reg(CFG_TIMEOUT, tmo);
        i_cfg_we <= 1'b0;
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening at reset register values
        send_tick();
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd19);
        send_beat(1'b0, 16'd20);
        send_pulse_us(1500);
        send_beat(1'b0, 16'hFFFF);
        send_pulse_us(3000);
        send_pulse_us(600);
        send_pulse_us(2499);
        send_pulse_us(1500);
        send_pulse_us(1000);
        send_pulse_us(2000);
        send_pulse_us(1234);
        send_pulse_us(700);
        send_pulse_us(2400);
        send_pulse_us(2500);
        send_pulse_us(29999);
        send_pulse_us(1100);
        send_pulse_us(1300);
        send_pulse_us(1520);
        send_pulse_us(1700);
        send_pulse_us(1900);
        send_pulse_us(650);
        send_pulse_us(2450);
        send_pulse_us(1800);
        drain();

        use_setting(7, 3, 2700, 40000, 700, 2300, 0, 1);
        hold_req = 1'b1;
        run_phase(300);
        drain();

        // everything reads as sync, so no frame can complete
        use_setting(0, 7, 0, 40000, 0, 40000, 4095, 255);
        run_phase(50);
        drain();

        // overlapping ranges, throttle and steering on one slot
        use_setting(4, 4, 2000, 5000, 500, 3000, 300, 20);
        run_phase(250);
        drain();

        // wide channel values that saturate the slots
        use_setting(1, 6, 5000, 40000, 0, 5000, 1000, 8);
        hold_req = 1'b1;
        run_phase(250);
        drain();

        use_setting(2, 0, 3000, 30000, 600, 2500, 600, 50);
        run_phase(250);
        quiet     = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(150);
        drain();

        if (chk_errors == 0 && chk_pending == 0) begin
            $display("[cppm_frame_decoder_with_calibration] OK");
        end else begin
            $display("[cppm_frame_decoder_with_calibration] ERROR");
        end
        $finish;
    end

endmodule

@@ cppm_frame_decoder_with_calibration.f @@
hw/rtl/cfdc_pkg.sv
hw/rtl/cfdc_conv.sv
hw/rtl/cfdc_core.sv
hw/rtl/cppm_frame_decoder_with_calibration.sv
verif/cfdc_result_check.sv
verif/tb.sv
